// ===== rtl/core/cai_pkg.sv =====
// Shared types, widths and helpers of the complex arithmetic unit.
// No dependencies; every other file of the unit imports this package.
`default_nettype none

package cai_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;       // exact product
    localparam int SUM_W      = PROD_W + 2;           // sum of two products, signed
    localparam int REM_W      = PROD_W + 1;           // divider partial remainder
    localparam int XW         = PROD_W + FRAC_BITS;   // scaled dividend

    typedef enum logic [1:0] {
        K_ADD = 2'd0,
        K_SUB = 2'd1,
        K_MUL = 2'd2,
        K_DIV = 2'd3
    } t_kind;

    // one finished result part
    typedef struct packed {
        logic [DATA_WIDTH-1:0] val;
        logic                  ovf;
    } t_part;

    // one divider lane
    typedef struct packed {
        logic                  neg;
        logic                  big;   // quotient does not fit in DATA_WIDTH bits
        logic [REM_W-1:0]      rem;
        logic [DATA_WIDTH-1:0] lo;    // dividend bits still to shift in
        logic [DATA_WIDTH-1:0] q;
    } t_lane;

    // what travels from cell to cell
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              dz;
        logic [PROD_W-1:0] den;
        t_lane             re;
        t_lane             im;
        t_part             pre;   // finished result for items that skip division
        t_part             pim;
    } t_cell;

    // clamp a sign/magnitude value to DATA_WIDTH bits two's complement
    function automatic t_part sat_part(input logic neg, input logic [SUM_W-1:0] mag);
        logic [SUM_W-1:0] lim;
        logic [SUM_W-1:0] m;
        logic [SUM_W-1:0] tc;
        t_part            p;
        lim   = neg ? (SUM_W'(1) << (DATA_WIDTH - 1))
                    : ((SUM_W'(1) << (DATA_WIDTH - 1)) - SUM_W'(1));
        p.ovf = (mag > lim);
        m     = p.ovf ? lim : mag;
        tc    = neg ? (~m + SUM_W'(1)) : m;
        p.val = tc[DATA_WIDTH-1:0];
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cai_cell.sv =====
// One restoring-division cell: one quotient bit for both result parts.
// Depends on cai_pkg.
`default_nettype none

module cai_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  cai_pkg::t_cell     i_cell,
    output cai_pkg::t_cell     o_cell
);
    import cai_pkg::*;

    t_cell n_cell;
    t_cell r_cell;

    function automatic t_lane lane_step(input t_lane l, input logic [PROD_W-1:0] den);
        logic [REM_W-1:0] sh;
        logic             ge;
        t_lane            n;
        sh    = {l.rem[REM_W-2:0], l.lo[DATA_WIDTH-1]};
        ge    = (sh >= REM_W'(den));
        n     = l;
        n.rem = ge ? (sh - REM_W'(den)) : sh;
        n.lo  = {l.lo[DATA_WIDTH-2:0], 1'b0};
        n.q   = {l.q[DATA_WIDTH-2:0], ge};
        return n;
    endfunction

    always_comb begin
        n_cell    = i_cell;
        n_cell.re = lane_step(i_cell.re, i_cell.den);
        n_cell.im = lane_step(i_cell.im, i_cell.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.is_div <= n_cell.is_div;
            r_cell.dz     <= n_cell.dz;
            r_cell.den    <= n_cell.den;
            r_cell.re     <= n_cell.re;
            r_cell.im     <= n_cell.im;
            r_cell.pre    <= n_cell.pre;
            r_cell.pim    <= n_cell.pim;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

// ===== rtl/core/cai_front.sv =====
// Front stages: operand register, products, sums, then the head item of the cell chain.
// Depends on cai_pkg.
`default_nettype none

module cai_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_ld,      // first stage loads
    input  wire logic                          i_en,      // later stages advance
    input  wire logic                          i_valid,
    input  wire logic [1:0]                    i_kind,
    input  wire logic [cai_pkg::DATA_WIDTH-1:0] i_a_re,
    input  wire logic [cai_pkg::DATA_WIDTH-1:0] i_a_im,
    input  wire logic [cai_pkg::DATA_WIDTH-1:0] i_b_re,
    input  wire logic [cai_pkg::DATA_WIDTH-1:0] i_b_im,
    output logic                               o_full,    // first stage holds an item
    output cai_pkg::t_cell                     o_head
);
    import cai_pkg::*;

    // stage 1: operands
    logic                         r_v1;
    t_kind                        r_k1;
    logic signed [DATA_WIDTH-1:0] r_ar, r_ai, r_br, r_bi;

    // stage 2: products and sums
    logic                         r_v2;
    t_kind                        r_k2;
    logic                         r_dz2, r_nar2, r_nai2;
    logic signed [PROD_W-1:0]     r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_sq_r, r_sq_i;
    logic signed [SUM_W-1:0]      r_s_re, r_s_im;

    // stage 3: combined values and denominator
    logic                         r_v3;
    t_kind                        r_k3;
    logic                         r_dz3, r_nar3, r_nai3;
    logic signed [SUM_W-1:0]      r_val_re, r_val_im;
    logic [PROD_W-1:0]            r_den;

    logic signed [SUM_W-1:0]      n_val_re, n_val_im;
    logic                         neg_re, neg_im;
    logic [SUM_W-1:0]             mag_re, mag_im, nd_re, nd_im;
    logic [XW-1:0]                x_re, x_im;
    logic [REM_W-1:0]             hi_re, hi_im;
    logic [DATA_WIDTH-1:0]        v_max, v_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (i_ld) begin
                r_v1 <= i_valid;
            end
            if (i_en) begin
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
        if (i_ld) begin
            r_k1 <= t_kind'(i_kind);
            r_ar <= i_a_re;
            r_ai <= i_a_im;
            r_br <= i_b_re;
            r_bi <= i_b_im;
        end
        if (i_en) begin
            r_k2   <= r_k1;
            r_dz2  <= (r_br == '0) && (r_bi == '0);
            r_nar2 <= r_ar[DATA_WIDTH-1];
            r_nai2 <= r_ai[DATA_WIDTH-1];
            r_p_rr <= r_ar * r_br;
            r_p_ii <= r_ai * r_bi;
            r_p_ri <= r_ar * r_bi;
            r_p_ir <= r_ai * r_br;
            r_sq_r <= r_br * r_br;
            r_sq_i <= r_bi * r_bi;
            r_s_re <= (r_k1 == K_SUB) ? (SUM_W'(r_ar) - SUM_W'(r_br))
                                      : (SUM_W'(r_ar) + SUM_W'(r_br));
            r_s_im <= (r_k1 == K_SUB) ? (SUM_W'(r_ai) - SUM_W'(r_bi))
                                      : (SUM_W'(r_ai) + SUM_W'(r_bi));

            r_k3     <= r_k2;
            r_dz3    <= r_dz2;
            r_nar3   <= r_nar2;
            r_nai3   <= r_nai2;
            r_val_re <= n_val_re;
            r_val_im <= n_val_im;
            r_den    <= PROD_W'(r_sq_r) + PROD_W'(r_sq_i);
        end
    end

    always_comb begin
        case (r_k2)
            K_MUL: begin
                n_val_re = SUM_W'(r_p_rr) - SUM_W'(r_p_ii);
                n_val_im = SUM_W'(r_p_ri) + SUM_W'(r_p_ir);
            end
            K_DIV: begin
                n_val_re = SUM_W'(r_p_rr) + SUM_W'(r_p_ii);
                n_val_im = SUM_W'(r_p_ir) - SUM_W'(r_p_ri);
            end
            default: begin
                n_val_re = r_s_re;
                n_val_im = r_s_im;
            end
        endcase
    end

    // sign/magnitude split, then either the finished result or the divider start
    always_comb begin
        v_max  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        v_min  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        neg_re = r_val_re[SUM_W-1];
        neg_im = r_val_im[SUM_W-1];
        mag_re = neg_re ? (~r_val_re + SUM_W'(1)) : r_val_re;
        mag_im = neg_im ? (~r_val_im + SUM_W'(1)) : r_val_im;
        nd_re  = (r_k3 == K_MUL) ? (mag_re >> FRAC_BITS) : mag_re;
        nd_im  = (r_k3 == K_MUL) ? (mag_im >> FRAC_BITS) : mag_im;
        x_re   = XW'(mag_re) << FRAC_BITS;
        x_im   = XW'(mag_im) << FRAC_BITS;
        hi_re  = REM_W'(x_re[XW-1:DATA_WIDTH]);
        hi_im  = REM_W'(x_im[XW-1:DATA_WIDTH]);

        o_head.valid  = r_v3;
        o_head.is_div = (r_k3 == K_DIV);
        o_head.dz     = (r_k3 == K_DIV) && r_dz3;
        o_head.den    = r_den;
        o_head.re.neg = neg_re;
        o_head.re.big = (hi_re >= REM_W'(r_den));
        o_head.re.rem = hi_re;
        o_head.re.lo  = x_re[DATA_WIDTH-1:0];
        o_head.re.q   = '0;
        o_head.im.neg = neg_im;
        o_head.im.big = (hi_im >= REM_W'(r_den));
        o_head.im.rem = hi_im;
        o_head.im.lo  = x_im[DATA_WIDTH-1:0];
        o_head.im.q   = '0;
        if (r_k3 == K_DIV) begin
            // divide by zero: saturate toward the sign of the first operand
            o_head.pre.val = r_nar3 ? v_min : v_max;
            o_head.pre.ovf = 1'b0;
            o_head.pim.val = r_nai3 ? v_min : v_max;
            o_head.pim.ovf = 1'b0;
        end else begin
            o_head.pre = sat_part(neg_re, nd_re);
            o_head.pim = sat_part(neg_im, nd_im);
        end
    end

    assign o_full = r_v1;

endmodule

`default_nettype wire

// ===== rtl/core/complex_arith_unit.sv =====
// Top level of the complex arithmetic unit: front stages, division cell chain, output register.
// Depends on cai_pkg, cai_front and cai_cell.
//
//  channel | dir | tdata (low bit up)                  | tuser (low bit up)
//  --------+-----+-------------------------------------+---------------------------
//  s       | in  | a_re[31:0] a_im b_re b_im (128 b)   | kind[1:0]
//  m       | out | res_re[31:0] res_im (64 b)          | overflow, divide_by_zero
//
// The unit takes one item per cycle, for every kind, while the output is not stalled.
// The chain of DATA_WIDTH division cells, one quotient bit per cell, sets the latency;
// add, subtract and multiply results ride along the same chain to keep order.
// Reset (synchronous, active low) clears only the valid bits of all stages.
// A stalled output freezes the whole pipeline; the first stage still takes an item
// while it is empty.
`default_nettype none

module complex_arith_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [127:0]  i_s_tdata,   // a_re, a_im, b_re, b_im
    input  wire logic [1:0]    i_s_tuser,   // kind
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [63:0]        o_m_tdata,   // res_re, res_im
    output logic [1:0]         o_m_tuser    // overflow, divide_by_zero
);
    import cai_pkg::*;

    localparam int DW = DATA_WIDTH;

    logic  en;
    logic  s1_full;
    t_cell w_link [0:DW];
    t_cell tail;
    t_part fin_re, fin_im;
    logic  fin_ovf;

    logic          r_out_valid;
    logic [DW-1:0] r_res_re, r_res_im;
    logic          r_ovf, r_dz;

    // whole pipeline advances whenever the output register can take an item
    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en || !s1_full;

    cai_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (o_s_tready),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_kind  (i_s_tuser),
        .i_a_re  (i_s_tdata[DW-1:0]),
        .i_a_im  (i_s_tdata[2*DW-1:DW]),
        .i_b_re  (i_s_tdata[3*DW-1:2*DW]),
        .i_b_im  (i_s_tdata[4*DW-1:3*DW]),
        .o_full  (s1_full),
        .o_head  (w_link[0])
    );

    for (genvar g = 0; g < DW; g++) begin : g_cell
        cai_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cell  (w_link[g]),
            .o_cell  (w_link[g+1])
        );
    end

    assign tail = w_link[DW];

    // for a divide, the quotient plus the too-large flag, clamped to the output width; else the finished result
    always_comb begin
        if (tail.is_div && !tail.dz) begin
            fin_re = sat_part(tail.re.neg, SUM_W'({tail.re.big, tail.re.q}));
            fin_im = sat_part(tail.im.neg, SUM_W'({tail.im.big, tail.im.q}));
        end else begin
            fin_re = tail.pre;
            fin_im = tail.pim;
        end
        fin_ovf = fin_re.ovf || fin_im.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= tail.valid;
        end
        if (en) begin
            r_res_re <= fin_re.val;
            r_res_im <= fin_im.val;
            r_ovf    <= fin_ovf;
            r_dz     <= tail.dz;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_res_im, r_res_re};
    assign o_m_tuser  = {r_dz, r_ovf};

    // divide by zero never reports overflow
    a_dz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_dz) |-> !r_ovf)
        else $error("divide by zero item also flags overflow");

    // divide by zero gives saturated parts; this check covers the real part
    a_dz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_dz) |->
            ((r_res_re == {1'b0, {(DW-1){1'b1}}}) || (r_res_re == {1'b1, {(DW-1){1'b0}}})))
        else $error("divide by zero result not saturated");

    // an overflow leaves at least one part at a limit
    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ovf) |->
            ((r_res_re == {1'b0, {(DW-1){1'b1}}}) || (r_res_re == {1'b1, {(DW-1){1'b0}}}) ||
             (r_res_im == {1'b0, {(DW-1){1'b1}}}) || (r_res_im == {1'b1, {(DW-1){1'b0}}})))
        else $error("overflow flagged without a saturated part");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench of complex_arith_unit: add, subtract, multiply and divide of Q16.16 operands.
// Depends on cai_pkg and the unit's RTL. Results are predicted in place and checked in order.
`timescale 1ns / 100ps

module testbench;
    import cai_pkg::*;

    localparam int W         = DATA_WIDTH;
    localparam int LIMIT     = 400000;
    localparam int LAT       = DATA_WIDTH + 4;
    localparam int N_RANDOM  = 1130;

    typedef struct packed {
        logic [W-1:0] re;
        logic [W-1:0] im;
        logic         ovf;
        logic         dz;
    } t_res;

    typedef struct packed {
        t_kind        kind;
        logic [W-1:0] a_re;
        logic [W-1:0] a_im;
        logic [W-1:0] b_re;
        logic [W-1:0] b_im;
    } t_op;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [127:0] i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [63:0]  o_m_tdata;
    logic [1:0]   o_m_tuser;

    t_op  op_queue[$];
    t_res result_queue[$];
    int   errors = 0;
    int   cycle = 0;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_cycles = 0;
    bit   hold_req = 1'b0;
    bit   hold_done = 1'b0;

    complex_arith_unit i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Saturate a sign/magnitude value of wide magnitude to W bits.
    function automatic logic [W-1:0] clamp(input logic neg, input logic [255:0] mag,
                                           inout logic ovf);
        logic [255:0] lim;
        lim = neg ? (256'(1) << (W - 1)) : ((256'(1) << (W - 1)) - 1);
        if (mag > lim) begin
            ovf = 1'b1;
            mag = lim;
        end
        return neg ? W'(~mag + 1) : W'(mag);
    endfunction

    // Exact complex arithmetic with 256-bit signed intermediates.
    function automatic t_res complex_result(input t_op op);
        logic signed [255:0] ar, ai, br, bi, re, im, den;
        logic [255:0]        mre, mim;
        logic                nre, nim, ovf;
        t_res                r;
        ar  = 256'(signed'(op.a_re));
        ai  = 256'(signed'(op.a_im));
        br  = 256'(signed'(op.b_re));
        bi  = 256'(signed'(op.b_im));
        ovf = 1'b0;
        r   = '0;
        case (op.kind)
            K_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            K_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            K_MUL: begin
                re = ar * br - ai * bi;
                im = ar * bi + ai * br;
            end
            default: begin
                re  = ar * br + ai * bi;
                im  = ai * br - ar * bi;
                den = br * br + bi * bi;
            end
        endcase
        nre = re < 0;
        nim = im < 0;
        mre = nre ? -re : re;
        mim = nim ? -im : im;
        if (op.kind == K_MUL) begin
            mre = mre >> FRAC_BITS;
            mim = mim >> FRAC_BITS;
        end else if (op.kind == K_DIV) begin
            if (den == 0) begin
                // divide by zero: parts follow the sign of the dividend parts
                r.re = op.a_re[W-1] ? W'(1) << (W - 1) : (W'(1) << (W - 1)) - 1;
                r.im = op.a_im[W-1] ? W'(1) << (W - 1) : (W'(1) << (W - 1)) - 1;
                r.dz = 1'b1;
                return r;
            end
            mre = (mre << FRAC_BITS) / 256'(den);
            mim = (mim << FRAC_BITS) / 256'(den);
        end
        if (mre == 0) nre = 1'b0;
        if (mim == 0) nim = 1'b0;
        r.re  = clamp(nre, mre, ovf);
        r.im  = clamp(nim, mim, ovf);
        r.ovf = ovf;
        return r;
    endfunction

    task automatic push_op(input t_kind k, input logic [W-1:0] a, input logic [W-1:0] b,
                           input logic [W-1:0] c, input logic [W-1:0] d);
        t_op op;
        op.kind = k;
        op.a_re = a;
        op.a_im = b;
        op.b_re = c;
        op.b_im = d;
        op_queue.push_back(op);
    endtask

    function automatic logic [W-1:0] rand_part();
        case ($urandom_range(0, 7))
            0: return W'(32'h8000_0000);
            1: return W'(32'h7fff_ffff);
            2: return '0;
            3: return W'($urandom_range(0, 2**18)) - W'(2**17);
            4: return W'($urandom_range(0, 2**24)) - W'(2**23);
            default: return W'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle, what, got, want);
        errors++;
    endtask

    // Driver: offer queued items, idling at the current rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (op_queue.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
                t_op op;
                op = op_queue.pop_front();
                result_queue.push_back(complex_result(op));
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {op.b_im, op.b_re, op.a_im, op.a_re};
                i_s_tuser  <= op.kind;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready, with one long hold-off when asked.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done   <= 1'b1;
            hold_cycles <= 300;
            i_m_tready  <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready  <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(1, 100) > recv_idle_pct);
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (result_queue.size() == 0) begin
                $display("unexpected result at cycle %0d", cycle);
                errors++;
            end else begin
                t_res want;
                want = result_queue.pop_front();
                if (o_m_tdata[W-1:0] !== want.re)
                    report_mismatch("res_re", o_m_tdata[W-1:0], want.re);
                if (o_m_tdata[2*W-1:W] !== want.im)
                    report_mismatch("res_im", o_m_tdata[2*W-1:W], want.im);
                if (o_m_tuser[0] !== want.ovf)
                    report_mismatch("overflow", W'(o_m_tuser[0]), W'(want.ovf));
                if (o_m_tuser[1] !== want.dz)
                    report_mismatch("divide_by_zero", W'(o_m_tuser[1]), W'(want.dz));
            end
        end
        if (cycle > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [W-1:0] mx, mn;
        send_idle_pct = 36;
        recv_idle_pct = 53;
        i_rst_n       = 1'b0;
        mx = (W'(1) << (W - 1)) - 1;
        mn = W'(1) << (W - 1);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every kind, saturation, divide by zero
        push_op(K_ADD, mx, mn, mx, mn);
        push_op(K_ADD, mn, mx, mn, mx);
        push_op(K_SUB, mx, mn, mn, mx);
        push_op(K_SUB, mn, '0, mn, '0);
        push_op(K_ADD, '0, '0, '0, '0);
        push_op(K_MUL, mx, mx, mx, mx);
        push_op(K_MUL, mn, mn, mn, mn);
        push_op(K_MUL, mn, mx, mx, mn);
        push_op(K_MUL, W'(32'h0001_0000), '0, W'(32'hffff_ffff), W'(1));
        push_op(K_MUL, W'(-1), W'(-1), W'(1), W'(1));
        push_op(K_DIV, mx, mn, '0, '0);
        push_op(K_DIV, mn, mx, '0, '0);
        push_op(K_DIV, '0, '0, '0, '0);
        push_op(K_DIV, W'(-5), W'(7), '0, '0);
        push_op(K_DIV, mx, mx, W'(1), '0);
        push_op(K_DIV, mn, mn, '0, W'(1));
        push_op(K_DIV, W'(32'h0003_0000), W'(32'h0004_0000), W'(32'h0001_0000), W'(32'hffff_0000));
        push_op(K_DIV, W'(1), W'(-1), mx, mn);
        push_op(K_DIV, mn, mn, mn, mn);
        push_op(K_DIV, W'(-7), W'(3), W'(32'h0002_0000), W'(32'h0003_0000));

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                wait (op_queue.size() == 0 && result_queue.size() == 0);
                send_idle_pct = 53;
                recv_idle_pct = 36;
            end
            if (i == 2 * N_RANDOM / 3) begin
                wait (op_queue.size() == 0 && result_queue.size() == 0);
                send_idle_pct = 0;
                recv_idle_pct = 0;
                @(posedge i_clk);
                hold_req = 1'b1;   // long stall: pipeline fills, input backs up
            end
            push_op(t_kind'($urandom_range(0, 3)), rand_part(), rand_part(),
                    rand_part(), rand_part());
        end

        wait (op_queue.size() == 0 && !i_s_tvalid && result_queue.size() == 0);
        repeat (2 * LAT) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
